// ===== rtl/rawk_pkg.sv =====
package rawk_pkg;

    localparam int MAX_TYPES_DEF   = 32;
    localparam int MAX_PACKET_DEF  = 4096;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam int HDR_SIZE   = 20;
    localparam int POS_CODE   = 0;
    localparam int POS_LEN_HI = 2;
    localparam int POS_LEN_LO = 3;
    localparam int POS_HDR_LEN_END = 4;

    localparam int TYPE_W   = 5;
    localparam int OFF_W    = 12;
    localparam int LEN_W    = 8;
    localparam int BITMAP_W = 32;
    localparam int DLEN_W   = 16;
    localparam int M_DATA_W = 64;

    localparam logic KIND_ATTR    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_WRONG_CODE = 2'd1,
        ST_NO_ATTR    = 2'd2,
        ST_SHORT      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        PH_TYPE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2
    } phase_t;

    typedef struct packed {
        logic                has_attr;
        logic [TYPE_W-1:0]   a_type;
        logic [OFF_W-1:0]    a_off;
        logic [LEN_W-1:0]    a_len;
        logic                has_sum;
        status_t             status;
        logic [BITMAP_W-1:0] bitmap;
    } entry_t;

endpackage

// ===== rtl/radius_attribute_walker_core.sv =====
// Channel  Direction  tdata                                        tuser        tlast
// s_       in         [7:0] data_byte                              none         last_byte
// m_       out        [4:0] type, [16:5] offset, [24:17] length,   record_kind  end_of_run
//                     [26:25] status, [58:27] present_bitmap
// cfg_     in         [7:0] accepted_code (cfg_wdata)              none         none
//
// One input byte is taken every cycle while the result queue has room.
// Each byte updates the parser in the cycle it is taken; its results are
// queued and leave one per cycle while m_tready is high, so a byte that yields
// a record and a summary sends the record first and then the summary.
// Reset is synchronous and clears the parser, the queue and accepted_code to 4.
// A stalled output fills the queue, after which s_tready drops.
module radius_attribute_walker_core #(
    parameter int MAX_TYPES   = rawk_pkg::MAX_TYPES_DEF,
    parameter int MAX_PACKET  = rawk_pkg::MAX_PACKET_DEF,
    parameter int QUEUE_DEPTH = rawk_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [7:0]                    cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] data_byte
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rawk_pkg::M_DATA_W-1:0] m_tdata,   // type, offset, length, status, bitmap
    output logic                          m_tuser,   // [0] record_kind
    output logic                          m_tlast
);

    logic [7:0]       accepted_code_reg;
    logic             in_accept;
    logic             push;
    logic             full;
    logic             pop;
    logic             head_valid;
    rawk_pkg::entry_t push_entry;
    rawk_pkg::entry_t head_entry;

    assign s_tready  = !full;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            accepted_code_reg <= 8'd4;
        end else if (cfg_we) begin
            accepted_code_reg <= cfg_wdata;
        end
    end

    rawk_front #(
        .MAX_TYPES (MAX_TYPES),
        .MAX_PACKET(MAX_PACKET)
    ) u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accepted_code(accepted_code_reg),
        .in_accept    (in_accept),
        .in_byte      (s_tdata),
        .in_last      (s_tlast),
        .push         (push),
        .push_entry   (push_entry)
    );

    rawk_queue #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_entry(push_entry),
        .full      (full),
        .pop       (pop),
        .head_valid(head_valid),
        .head_entry(head_entry)
    );

    rawk_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .head_valid(head_valid),
        .head_entry(head_entry),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

`ifndef SYNTHESIS
    a_attr_then_summary: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tuser == rawk_pkg::KIND_ATTR && !m_tlast)
        |=> (m_tvalid && m_tuser == rawk_pkg::KIND_SUMMARY))
        else $error("attribute record without its summary");
    a_summary_ends_run: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == rawk_pkg::KIND_SUMMARY) |-> m_tlast)
        else $error("summary not marked as end of run");
    a_attr_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == rawk_pkg::KIND_ATTR) |-> (m_tdata[58:25] == '0))
        else $error("attribute record carries status or bitmap");
    a_push_when_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> in_accept)
        else $error("queue write without an input transfer");
`endif

endmodule

// ===== rtl/rawk_front.sv =====
module rawk_front #(
    parameter int MAX_TYPES  = rawk_pkg::MAX_TYPES_DEF,
    parameter int MAX_PACKET = rawk_pkg::MAX_PACKET_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [7:0]      accepted_code,
    input  logic            in_accept,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    output logic            push,
    output rawk_pkg::entry_t push_entry
);

    localparam int PW = $clog2(MAX_PACKET + 1);
    localparam int DW = rawk_pkg::DLEN_W;

    logic [PW-1:0]                     pos_reg, pos_next;
    logic [7:0]                        code_reg, code_next;
    logic [DW-1:0]                     dlen_reg, dlen_next;
    rawk_pkg::phase_t                  phase_reg, phase_next;
    logic [7:0]                        ctype_reg, ctype_next;
    logic [7:0]                        left_reg, left_next;
    logic [rawk_pkg::OFF_W-1:0]        astart_reg, astart_next;
    logic [rawk_pkg::BITMAP_W-1:0]     seen_reg, seen_next;
    logic                              stopped_reg, stopped_next;

    logic [DW-1:0] p16;
    logic [DW-1:0] room;
    logic [7:0]    left_dec;
    logic          attr_hit;
    rawk_pkg::status_t status;

    always_comb begin
        pos_next     = pos_reg;
        code_next    = code_reg;
        dlen_next    = dlen_reg;
        phase_next   = phase_reg;
        ctype_next   = ctype_reg;
        left_next    = left_reg;
        astart_next  = astart_reg;
        seen_next    = seen_reg;
        stopped_next = stopped_reg;
        attr_hit     = 1'b0;
        p16          = DW'(pos_reg);
        room         = dlen_reg - DW'(astart_reg);
        left_dec     = (left_reg != 8'd0) ? (left_reg - 8'd1) : left_reg;
        status       = rawk_pkg::ST_OK;

        if (pos_reg < PW'(MAX_PACKET)) begin
            pos_next = pos_reg + PW'(1);
            if (p16 == DW'(rawk_pkg::POS_CODE)) begin
                code_next = in_byte;
            end else if (p16 == DW'(rawk_pkg::POS_LEN_HI)) begin
                dlen_next = {in_byte, dlen_reg[7:0]};
            end else if (p16 == DW'(rawk_pkg::POS_LEN_LO)) begin
                dlen_next = {dlen_reg[15:8], in_byte};
            end else if (p16 >= DW'(rawk_pkg::HDR_SIZE) && p16 < dlen_reg && !stopped_reg
                         && code_reg == accepted_code) begin
                unique case (phase_reg)
                    rawk_pkg::PH_TYPE: begin
                        ctype_next  = in_byte;
                        astart_next = p16[rawk_pkg::OFF_W-1:0];
                        if (p16 + DW'(1) == dlen_reg) begin
                            seen_next    = '0;
                            stopped_next = 1'b1;
                        end else begin
                            phase_next = rawk_pkg::PH_LEN;
                        end
                    end
                    rawk_pkg::PH_LEN: begin
                        if (in_byte < 8'd2 || DW'(in_byte) > room) begin
                            seen_next    = '0;
                            stopped_next = 1'b1;
                        end else begin
                            if ({1'b0, ctype_reg} < 9'(MAX_TYPES)) begin
                                seen_next = seen_reg
                                    | (rawk_pkg::BITMAP_W'(1) << ctype_reg[4:0]);
                                attr_hit  = 1'b1;
                            end
                            left_next  = in_byte - 8'd2;
                            phase_next = (in_byte == 8'd2) ? rawk_pkg::PH_TYPE
                                                           : rawk_pkg::PH_VALUE;
                        end
                    end
                    rawk_pkg::PH_VALUE: begin
                        left_next = left_dec;
                        if (left_dec == 8'd0) begin
                            phase_next = rawk_pkg::PH_TYPE;
                        end
                    end
                    default: begin
                        phase_next = rawk_pkg::PH_TYPE;
                    end
                endcase
            end
        end

        if (code_next != accepted_code) begin
            status = rawk_pkg::ST_WRONG_CODE;
        end else if (pos_next < PW'(rawk_pkg::POS_HDR_LEN_END)
                     || dlen_next < DW'(rawk_pkg::HDR_SIZE)
                     || DW'(pos_next) < dlen_next) begin
            status = rawk_pkg::ST_SHORT;
        end else if (seen_next == '0) begin
            status = rawk_pkg::ST_NO_ATTR;
        end

        push_entry.has_attr = attr_hit;
        push_entry.a_type   = ctype_reg[rawk_pkg::TYPE_W-1:0];
        push_entry.a_off    = astart_reg;
        push_entry.a_len    = in_byte;
        push_entry.has_sum  = in_last;
        push_entry.status   = status;
        push_entry.bitmap   = seen_next;
        push = in_accept && (attr_hit || in_last);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg     <= '0;
            code_reg    <= '0;
            dlen_reg    <= '0;
            phase_reg   <= rawk_pkg::PH_TYPE;
            ctype_reg   <= '0;
            left_reg    <= '0;
            astart_reg  <= '0;
            seen_reg    <= '0;
            stopped_reg <= 1'b0;
        end else if (in_accept) begin
            if (in_last) begin
                pos_reg     <= '0;
                code_reg    <= '0;
                dlen_reg    <= '0;
                phase_reg   <= rawk_pkg::PH_TYPE;
                ctype_reg   <= '0;
                left_reg    <= '0;
                astart_reg  <= '0;
                seen_reg    <= '0;
                stopped_reg <= 1'b0;
            end else begin
                pos_reg     <= pos_next;
                code_reg    <= code_next;
                dlen_reg    <= dlen_next;
                phase_reg   <= phase_next;
                ctype_reg   <= ctype_next;
                left_reg    <= left_next;
                astart_reg  <= astart_next;
                seen_reg    <= seen_next;
                stopped_reg <= stopped_next;
            end
        end
    end

endmodule

// ===== rtl/rawk_queue.sv =====
module rawk_queue #(
    parameter int QUEUE_DEPTH = rawk_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  rawk_pkg::entry_t push_entry,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output rawk_pkg::entry_t head_entry
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    rawk_pkg::entry_t mem [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;

    assign full       = (count_reg == CW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

// ===== rtl/rawk_back.sv =====
module rawk_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          head_valid,
    input  rawk_pkg::entry_t              head_entry,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rawk_pkg::M_DATA_W-1:0] m_tdata,
    output logic                          m_tuser,
    output logic                          m_tlast
);

    logic sel_reg, sel_next;
    logic send_attr;
    logic xfer;

    always_comb begin
        send_attr = head_entry.has_attr && !sel_reg;
        xfer      = head_valid && m_tready;
        m_tvalid  = head_valid;
        if (send_attr) begin
            m_tuser = rawk_pkg::KIND_ATTR;
            m_tlast = !head_entry.has_sum;
            m_tdata = {5'd0, 32'd0, rawk_pkg::ST_OK, head_entry.a_len,
                       head_entry.a_off, head_entry.a_type};
        end else begin
            m_tuser = rawk_pkg::KIND_SUMMARY;
            m_tlast = 1'b1;
            m_tdata = {5'd0, head_entry.bitmap, head_entry.status, 8'd0, 12'd0, 5'd0};
        end
        pop      = xfer && !(send_attr && head_entry.has_sum);
        sel_next = sel_reg;
        if (xfer) begin
            sel_next = send_attr && head_entry.has_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sel_reg <= 1'b0;
        end else begin
            sel_reg <= sel_next;
        end
    end

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import rawk_pkg::*;

    typedef struct {
        logic        kind;
        logic [4:0]  atype;
        logic [11:0] offset;
        logic [7:0]  length;
        status_t     st;
        logic [31:0] bitmap;
        logic        eor;
    } walk_rec_t;

    logic                aclk;
    logic                aresetn   = 1'b0;
    logic                cfg_we    = 1'b0;
    logic [7:0]          cfg_wdata = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [7:0]          s_tdata   = '0;   // [7:0] data_byte
    logic                s_tlast   = 1'b0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;          // [4:0] type, [16:5] offset, [24:17] length,
                                           // [26:25] status, [58:27] present_bitmap
    logic                m_tuser;          // [0] record_kind
    logic                m_tlast;

    radius_attribute_walker_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Parser state mirrored from the byte stream.
    logic [7:0]  acc_code;
    int          byte_pos;
    logic [7:0]  pkt_code;
    logic [15:0] decl_len;
    phase_t      walk_ph;
    logic [7:0]  cur_type;
    logic [7:0]  value_left;
    logic [11:0] attr_start;
    logic [31:0] seen_types;
    logic        walk_halted;

    walk_rec_t   expected_records[$];
    walk_rec_t   got_rec;
    walk_rec_t   want_rec;

    logic [7:0]  pkt_bytes[$];
    int          attr_starts[$];

    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    bit          hold_req      = 1'b0;
    int          hold_left     = 0;

    int          failures      = 0;
    int          bytes_sent    = 0;
    int          packets_sent  = 0;
    int          records_ok    = 0;
    int          code_writes   = 0;

    task clear_walk;
        byte_pos    = 0;
        pkt_code    = '0;
        decl_len    = '0;
        walk_ph     = PH_TYPE;
        cur_type    = '0;
        value_left  = '0;
        attr_start  = '0;
        seen_types  = '0;
        walk_halted = 1'b0;
    endtask

    task automatic walk_byte(input logic [7:0] b, input logic last);
        int        p;
        int        room;
        int        n;
        walk_rec_t rec;
        n = 0;
        if (byte_pos < MAX_PACKET_DEF) begin
            p = byte_pos;
            byte_pos++;
            if (p == POS_CODE) begin
                pkt_code = b;
            end else if (p == POS_LEN_HI) begin
                decl_len[15:8] = b;
            end else if (p == POS_LEN_LO) begin
                decl_len[7:0] = b;
            end else if (p >= HDR_SIZE && p < int'(decl_len) && !walk_halted &&
                         pkt_code == acc_code) begin
                case (walk_ph)
                    PH_TYPE: begin
                        cur_type   = b;
                        attr_start = p[11:0];
                        if (int'(decl_len) - p < 2) begin
                            seen_types  = '0;
                            walk_halted = 1'b1;
                        end else begin
                            walk_ph = PH_LEN;
                        end
                    end
                    PH_LEN: begin
                        room = int'(decl_len) - int'(attr_start);
                        if (int'(b) < 2 || int'(b) > room) begin
                            seen_types  = '0;
                            walk_halted = 1'b1;
                        end else begin
                            if (cur_type < MAX_TYPES_DEF) begin
                                seen_types[cur_type[4:0]] = 1'b1;
                                rec.kind   = KIND_ATTR;
                                rec.atype  = cur_type[4:0];
                                rec.offset = attr_start;
                                rec.length = b;
                                rec.st     = ST_OK;
                                rec.bitmap = '0;
                                rec.eor    = 1'b0;
                                expected_records.push_back(rec);
                                n++;
                            end
                            value_left = b - 8'd2;
                            walk_ph    = (value_left == 0) ? PH_TYPE : PH_VALUE;
                        end
                    end
                    default: begin
                        if (value_left > 0) value_left--;
                        if (value_left == 0) walk_ph = PH_TYPE;
                    end
                endcase
            end
        end
        if (last) begin
            rec.kind   = KIND_SUMMARY;
            rec.atype  = '0;
            rec.offset = '0;
            rec.length = '0;
            if (pkt_code != acc_code) begin
                rec.st = ST_WRONG_CODE;
            end else if (byte_pos < POS_HDR_LEN_END || decl_len < HDR_SIZE ||
                         byte_pos < int'(decl_len)) begin
                rec.st = ST_SHORT;
            end else if (seen_types == 0) begin
                rec.st = ST_NO_ATTR;
            end else begin
                rec.st = ST_OK;
            end
            rec.bitmap = seen_types;
            rec.eor    = 1'b0;
            expected_records.push_back(rec);
            n++;
            clear_walk();
        end
        if (n > 0) expected_records[expected_records.size()-1].eor = 1'b1;
    endtask

    always @(posedge aclk) begin
        if (hold_req) begin
            hold_left = 400;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_rec.kind   = m_tuser;
            got_rec.atype  = m_tdata[4:0];
            got_rec.offset = m_tdata[16:5];
            got_rec.length = m_tdata[24:17];
            got_rec.st     = status_t'(m_tdata[26:25]);
            got_rec.bitmap = m_tdata[58:27];
            got_rec.eor    = m_tlast;
            if (expected_records.size() == 0) begin
                $error("Output transfer arrived with no record expected.");
                failures++;
            end else begin
                want_rec = expected_records.pop_front();
                check_field("record_kind", want_rec.kind, got_rec.kind);
                check_field("attr_type", want_rec.atype, got_rec.atype);
                check_field("attr_offset", want_rec.offset, got_rec.offset);
                check_field("attr_length", want_rec.length, got_rec.length);
                check_field("status", want_rec.st, got_rec.st);
                check_field("present_bitmap", want_rec.bitmap, got_rec.bitmap);
                check_field("end_of_run", want_rec.eor, got_rec.eor);
                records_ok++;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do begin
                @(posedge aclk);
            end while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do begin
            @(posedge aclk);
        end while (!s_tready);
        walk_byte(b, last);
        bytes_sent++;
    endtask

    task automatic send_packet;
        for (int i = 0; i < pkt_bytes.size(); i++) begin
            send_byte(pkt_bytes[i], i == pkt_bytes.size() - 1);
        end
        packets_sent++;
    endtask

    task automatic add_noise(input int n);
        for (int i = 0; i < n; i++) pkt_bytes.push_back(8'($urandom_range(255)));
    endtask

    task automatic new_packet(input logic [7:0] code);
        pkt_bytes.delete();
        attr_starts.delete();
        pkt_bytes.push_back(code);
        add_noise(HDR_SIZE - 1);
    endtask

    task automatic add_attr(input int t, input int len);
        attr_starts.push_back(pkt_bytes.size());
        pkt_bytes.push_back(t[7:0]);
        pkt_bytes.push_back(len[7:0]);
        add_noise(len > 2 ? len - 2 : 0);
    endtask

    task automatic set_length(input int n);
        pkt_bytes[POS_LEN_HI] = n[15:8];
        pkt_bytes[POS_LEN_LO] = n[7:0];
    endtask

    task automatic cut_packet(input int n);
        pkt_bytes = pkt_bytes[0:n-1];
    endtask

    task stop_offer;
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    task drain;
        while (expected_records.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_code(input logic [7:0] code);
        stop_offer();
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= code;
        @(posedge aclk);
        cfg_we   <= 1'b0;
        acc_code  = code;
        code_writes++;
    endtask

    task automatic build_random_packet;
        int n;
        int k;
        int room;
        if ($urandom_range(9) == 0) begin
            pkt_bytes.delete();
            attr_starts.delete();
            add_noise($urandom_range(1, 30));
            if ($urandom_range(1)) pkt_bytes[POS_CODE] = acc_code;
            return;
        end
        new_packet($urandom_range(9) == 0 ? 8'($urandom_range(255)) : acc_code);
        n = $urandom_range(0, 4);
        for (int i = 0; i < n; i++) begin
            add_attr($urandom_range(6) == 0 ? $urandom_range(32, 255) : $urandom_range(31),
                     $urandom_range(7) == 0 ? $urandom_range(2, 40) : $urandom_range(2, 8));
        end
        set_length(pkt_bytes.size());
        case ($urandom_range(11))
            0: cut_packet($urandom_range(1, pkt_bytes.size() - 1));
            1: add_noise($urandom_range(1, 6));
            2: begin
                if (attr_starts.size() != 0) begin
                    k = $urandom_range(attr_starts.size() - 1);
                    pkt_bytes[attr_starts[k] + 1] = 8'($urandom_range(1));
                end
            end
            3: begin
                if (attr_starts.size() != 0) begin
                    k    = attr_starts[attr_starts.size() - 1];
                    room = pkt_bytes.size() - k + $urandom_range(1, 3);
                    pkt_bytes[k + 1] = room > 255 ? 8'd255 : room[7:0];
                end
            end
            4: begin
                pkt_bytes.push_back(8'($urandom_range(31)));
                set_length(pkt_bytes.size());
            end
            5: set_length($urandom_range(HDR_SIZE - 1));
            6: set_length($urandom_range(16'hFFFF));
            default: ;
        endcase
    endtask

    task test_walk_basics;
        new_packet(acc_code);
        add_attr(0, 2);
        add_attr(31, 40);
        add_attr(32, 3);
        add_attr(255, 2);
        add_attr(1, 3);
        set_length(pkt_bytes.size());
        send_packet();
        new_packet(acc_code);
        add_attr(17, 5);
        set_length(pkt_bytes.size());
        add_noise(4);
        send_packet();
    endtask

    task test_header_cases;
        for (int n = 1; n <= 3; n++) begin
            new_packet(acc_code);
            cut_packet(n);
            send_packet();
        end
        new_packet(acc_code ^ 8'h01);
        cut_packet(1);
        send_packet();
        new_packet(acc_code);
        add_attr(3, 2);
        set_length(HDR_SIZE - 1);
        send_packet();
        new_packet(acc_code);
        set_length(0);
        cut_packet(4);
        send_packet();
        new_packet(acc_code);
        set_length(HDR_SIZE);
        send_packet();
        new_packet(acc_code);
        add_attr(7, 4);
        set_length(16'hFFFF);
        send_packet();
        new_packet(acc_code + 8'd1);
        add_attr(2, 3);
        set_length(pkt_bytes.size());
        send_packet();
    endtask

    task test_walk_errors;
        for (int bad = 0; bad < 2; bad++) begin
            new_packet(acc_code);
            add_attr(3, 4);
            add_attr(9, 2);
            set_length(pkt_bytes.size());
            pkt_bytes[attr_starts[1] + 1] = bad[7:0];
            send_packet();
        end
        new_packet(acc_code);
        add_attr(4, 6);
        add_attr(5, 10);
        set_length(pkt_bytes.size() - 2);
        send_packet();
        new_packet(acc_code);
        add_attr(6, 4);
        pkt_bytes.push_back(8'd7);
        set_length(pkt_bytes.size());
        send_packet();
        new_packet(acc_code);
        add_attr(8, 20);
        set_length(pkt_bytes.size());
        cut_packet(pkt_bytes.size() - 5);
        send_packet();
        new_packet(acc_code);
        add_attr(200, 3);
        add_attr(32, 2);
        set_length(pkt_bytes.size());
        send_packet();
    endtask

    task test_backpressure;
        hold_req = 1'b1;
        new_packet(acc_code);
        for (int i = 0; i < 30; i++) add_attr($urandom_range(31), 2);
        set_length(pkt_bytes.size());
        send_packet();
    endtask

    task test_code_register;
        write_code(8'd0);
        new_packet(8'd0);
        add_attr(12, 3);
        set_length(pkt_bytes.size());
        send_packet();
        new_packet(8'd4);
        add_attr(13, 3);
        set_length(pkt_bytes.size());
        send_packet();
        write_code(8'd255);
        new_packet(8'd255);
        add_attr(14, 2);
        add_attr(30, 6);
        set_length(pkt_bytes.size());
        send_packet();
        new_packet(8'd0);
        set_length(HDR_SIZE);
        send_packet();
    endtask

    task automatic test_random(input int idle, input int stall, input int quota);
        int start;
        send_idle_pct = idle;
        stall_pct     = stall;
        start         = bytes_sent;
        while (bytes_sent - start < quota) begin
            build_random_packet();
            send_packet();
        end
    endtask

    initial begin
        acc_code = 8'd4;
        clear_walk();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_walk_basics();
        test_header_cases();
        test_walk_errors();
        test_backpressure();
        test_code_register();
        write_code(8'd4);
        test_random(0, 0, 40);
        write_code(8'($urandom_range(255)));
        test_random(75, 0, 40);
        write_code(8'($urandom_range(255)));
        test_random(0, 75, 40);
        write_code(8'd4);
        test_random(15, 15, 40);
        stop_offer();
        drain();
        $display("Walked %0d packets (%0d bytes) under %0d code settings; %0d records matched.",
                 packets_sent, bytes_sent, code_writes + 1, records_ok);
        $display("Covered header, length and attribute faults, a long output stall");
        $display("and four mixes of input and output idling.");
        if (failures == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rawk_pkg.sv
rtl/rawk_front.sv
rtl/rawk_queue.sv
rtl/rawk_back.sv
rtl/radius_attribute_walker_core.sv
verif/tb_top.sv
